[rtl/ccr_pkg.sv]
// ----------------------------------------------------------------------------
// ccr_pkg
// Shared types and constants of the QPSK carrier recovery loop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ccr_pkg;

	localparam int GUARD_BITS   = 14;
	localparam int XW_GROWTH    = GUARD_BITS + 3;   // guard bits plus CORDIC growth
	localparam int GAIN_BITS    = 16;
	localparam int COEF_WIDTH   = 18;
	localparam int FILT_SHIFT   = 8;
	localparam int CORDIC_ITERS = 16;
	localparam int ITER_W       = 4;
	localparam int CNT_W        = 9;
	localparam int RCNT_W       = 8;
	localparam int CFG_IDX_W    = 2;

	localparam logic [CNT_W-1:0]  CNT_MAX          = 9'd511;
	localparam logic [RCNT_W-1:0] RESET_COUNT_INIT = 8'd64;

	// 1/K of the CORDIC in Q0.16
	localparam logic signed [COEF_WIDTH-1:0] INV_GAIN = 18'sd39797;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KP          = 2'd0,
		CFG_KI          = 2'd1,
		CFG_RESET_COUNT = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		QUAD_0   = 2'd0,
		QUAD_90  = 2'd1,
		QUAD_180 = 2'd2,
		QUAD_270 = 2'd3
	} quad_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROT,
		ST_MULX,
		ST_MULY,
		ST_SATY,
		ST_ERR,
		ST_MULI,
		ST_MULP,
		ST_PHASE,
		ST_OUT
	} state_t;

	// atan(2^-i) as a 32-bit binary angle
	function automatic logic signed [31:0] atan_angle(input logic [ITER_W-1:0] idx);
		logic signed [31:0] a;
		case (idx)
			4'd0:    a = 32'sd536870912;
			4'd1:    a = 32'sd316933406;
			4'd2:    a = 32'sd167458907;
			4'd3:    a = 32'sd85004756;
			4'd4:    a = 32'sd42667331;
			4'd5:    a = 32'sd21354465;
			4'd6:    a = 32'sd10680862;
			4'd7:    a = 32'sd5340245;
			4'd8:    a = 32'sd2670163;
			4'd9:    a = 32'sd1335087;
			4'd10:   a = 32'sd667544;
			4'd11:   a = 32'sd333772;
			4'd12:   a = 32'sd166886;
			4'd13:   a = 32'sd83443;
			4'd14:   a = 32'sd41722;
			4'd15:   a = 32'sd20861;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

[rtl/ccr_stream_if.sv]
// ----------------------------------------------------------------------------
// ccr_stream_if
// Valid/ready channel carrying one complex sample per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ccr_stream_if #(parameter int W = 16);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] re;
	logic signed [W-1:0] im;

	modport source (output valid, output re, output im, input ready);
	modport sink   (input valid, input re, input im, output ready);
endinterface

[rtl/ccr_cordic.sv]
// ----------------------------------------------------------------------------
// ccr_cordic
// Iterative CORDIC rotator: quadrant pre-rotation, then one micro-rotation
// per cycle through a single shift/add unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_cordic #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           start,
	input  logic signed [SAMPLE_WIDTH-1:0]                 x_in,
	input  logic signed [SAMPLE_WIDTH-1:0]                 y_in,
	input  logic [31:0]                                    angle,
	output logic                                           done,
	output logic signed [SAMPLE_WIDTH+ccr_pkg::XW_GROWTH-1:0] x_out,
	output logic signed [SAMPLE_WIDTH+ccr_pkg::XW_GROWTH-1:0] y_out
);

	localparam int XW = SAMPLE_WIDTH + ccr_pkg::XW_GROWTH;

	logic signed [XW-1:0]             x_q, y_q;
	logic signed [31:0]               z_q;
	logic [ccr_pkg::ITER_W-1:0]       iter_q;
	logic                             busy_q, done_q;

	logic signed [XW-1:0] xe, ye, x0, y0, dx, dy;
	logic signed [31:0]   at;

	assign xe = XW'(x_in);
	assign ye = XW'(y_in);

	always_comb begin
		case (angle[31:30])
			ccr_pkg::QUAD_0: begin
				x0 = xe;
				y0 = ye;
			end
			ccr_pkg::QUAD_90: begin
				x0 = -ye;
				y0 = xe;
			end
			ccr_pkg::QUAD_180: begin
				x0 = -xe;
				y0 = -ye;
			end
			ccr_pkg::QUAD_270: begin
				x0 = ye;
				y0 = -xe;
			end
			default: begin
				x0 = xe;
				y0 = ye;
			end
		endcase
	end

	assign dx = y_q >>> iter_q;
	assign dy = x_q >>> iter_q;
	assign at = ccr_pkg::atan_angle(iter_q);

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0 <<< ccr_pkg::GUARD_BITS;
			y_q <= y0 <<< ccr_pkg::GUARD_BITS;
			z_q <= {2'b00, angle[29:0]};
		end else if (busy_q) begin
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			iter_q <= '0;
		end else if (busy_q) begin
			iter_q <= iter_q + 1'b1;
			if (iter_q == ccr_pkg::ITER_W'(ccr_pkg::CORDIC_ITERS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done  = done_q;
	assign x_out = x_q;
	assign y_out = y_q;

endmodule

[rtl/qpsk_carrier_recovery_loop_core.sv]
// ----------------------------------------------------------------------------
// qpsk_carrier_recovery_loop_core
// Decision-directed QPSK carrier recovery: de-rotates each sample by the
// tracked phase and updates the phase through a PI loop filter.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  in_ch     in   valid/ready         re, im  (Q1.15 sample)
//  out_ch    out  valid/ready         re, im  (de-rotated, saturated)
//  cfg       in   cfg_we, no stall    cfg_idx, cfg_data (kp, ki, reset_count)
//
//  The CORDIC runs its 16 micro-rotations and a done step, then seven steps
//  on the shared multiplier and adder (gain correction of re and im,
//  saturation, error, ki and kp products, phase update), then the output
//  register is loaded; in_ch.ready goes high in the same cycle as that
//  result becomes valid. in_ch.ready is high only between items; the result
//  sits in an output register, so the next item is taken while it waits,
//  and a held result stalls only the end of the following item. Reset
//  clears the loop state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpsk_carrier_recovery_loop_core #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int PHASE_WIDTH  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ccr_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [ccr_pkg::COEF_WIDTH-1:0]    cfg_data,
	ccr_stream_if.sink                        in_ch,
	ccr_stream_if.source                      out_ch
);

	localparam int XW  = SAMPLE_WIDTH + ccr_pkg::XW_GROWTH;
	localparam int MW  = XW + ccr_pkg::COEF_WIDTH;
	localparam int EW  = SAMPLE_WIDTH + 2;
	localparam int WW  = MW + PHASE_WIDTH;
	localparam int RSH = ccr_pkg::GUARD_BITS + ccr_pkg::GAIN_BITS;

	localparam logic signed [MW-1:0] RND_HALF = MW'(1) << (RSH - 1);
	localparam logic signed [MW-1:0] SMAX =
		{{(MW - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic signed [MW-1:0] SMIN = ~SMAX;

	ccr_pkg::state_t state_q, state_d;

	logic signed [ccr_pkg::COEF_WIDTH-1:0] kp_q, ki_q;
	logic [ccr_pkg::RCNT_W-1:0]            rcount_q;
	logic [PHASE_WIDTH-1:0]                integ_q, phase_q;
	logic [ccr_pkg::CNT_W-1:0]             cnt_q;

	logic signed [MW-1:0]           mul_q;
	logic signed [SAMPLE_WIDTH-1:0] ore_q, oim_q;
	logic signed [EW-1:0]           err_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_re_q, out_im_q;

	logic                           in_acc, out_load, clr;
	logic                           rot_done;
	logic signed [XW-1:0]           rot_x, rot_y;
	logic [PHASE_WIDTH-1:0]         neg_phase;
	logic [PHASE_WIDTH+31:0]        ang_ext;
	logic [31:0]                    angle;

	logic signed [XW-1:0]                  mul_a;
	logic signed [ccr_pkg::COEF_WIDTH-1:0] mul_b;
	logic signed [MW-1:0]                  prod;
	logic signed [MW-1:0]                  rnd;
	logic signed [SAMPLE_WIDTH-1:0]        sat_val;
	logic signed [EW-1:0]                  err_a, err_b, err_d;
	logic signed [WW-1:0]                  step_wide;
	logic [PHASE_WIDTH-1:0]                step;

	assign in_acc = in_ch.valid && in_ch.ready;

	// phase clear takes effect on the matching sample itself
	assign clr       = (cnt_q == {1'b0, rcount_q});
	assign neg_phase = clr ? '0 : ('0 - phase_q);
	assign ang_ext   = {neg_phase, 32'b0};
	assign angle     = ang_ext[PHASE_WIDTH+31 -: 32];

	ccr_cordic #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc),
		.x_in   (in_ch.re),
		.y_in   (in_ch.im),
		.angle  (angle),
		.done   (rot_done),
		.x_out  (rot_x),
		.y_out  (rot_y)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ccr_pkg::ST_IDLE:  if (in_acc) state_d = ccr_pkg::ST_ROT;
			ccr_pkg::ST_ROT:   if (rot_done) state_d = ccr_pkg::ST_MULX;
			ccr_pkg::ST_MULX:  state_d = ccr_pkg::ST_MULY;
			ccr_pkg::ST_MULY:  state_d = ccr_pkg::ST_SATY;
			ccr_pkg::ST_SATY:  state_d = ccr_pkg::ST_ERR;
			ccr_pkg::ST_ERR:   state_d = ccr_pkg::ST_MULI;
			ccr_pkg::ST_MULI:  state_d = ccr_pkg::ST_MULP;
			ccr_pkg::ST_MULP:  state_d = ccr_pkg::ST_PHASE;
			ccr_pkg::ST_PHASE: state_d = ccr_pkg::ST_OUT;
			ccr_pkg::ST_OUT:   if (!out_valid_q || out_ch.ready) state_d = ccr_pkg::ST_IDLE;
			default:           state_d = ccr_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs: handshake and multiplier operand select
	always_comb begin
		in_ch.ready = 1'b0;
		out_load    = 1'b0;
		mul_a       = '0;
		mul_b       = '0;
		case (state_q)
			ccr_pkg::ST_IDLE: in_ch.ready = 1'b1;
			ccr_pkg::ST_MULX: begin
				mul_a = rot_x;
				mul_b = ccr_pkg::INV_GAIN;
			end
			ccr_pkg::ST_MULY: begin
				mul_a = rot_y;
				mul_b = ccr_pkg::INV_GAIN;
			end
			ccr_pkg::ST_MULI: begin
				mul_a = XW'(err_q);
				mul_b = ki_q;
			end
			ccr_pkg::ST_MULP: begin
				mul_a = XW'(err_q);
				mul_b = kp_q;
			end
			ccr_pkg::ST_OUT: out_load = !out_valid_q || out_ch.ready;
			default: begin
				in_ch.ready = 1'b0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// round to nearest and saturate the gain-corrected value in mul_q
	assign rnd = (mul_q + RND_HALF) >>> RSH;
	always_comb begin
		if (rnd > SMAX)
			sat_val = SMAX[SAMPLE_WIDTH-1:0];
		else if (rnd < SMIN)
			sat_val = SMIN[SAMPLE_WIDTH-1:0];
		else
			sat_val = rnd[SAMPLE_WIDTH-1:0];
	end

	// zero counts as negative
	assign err_a = (ore_q > 0) ? EW'(oim_q) : -EW'(oim_q);
	assign err_b = (oim_q > 0) ? EW'(ore_q) : -EW'(ore_q);
	assign err_d = err_a - err_b;

	assign step_wide = WW'(mul_q >>> ccr_pkg::FILT_SHIFT);
	assign step      = step_wide[PHASE_WIDTH-1:0];

	always_ff @(posedge clk) begin
		mul_q <= prod;
		if (state_q == ccr_pkg::ST_MULY) ore_q <= sat_val;
		if (state_q == ccr_pkg::ST_SATY) oim_q <= sat_val;
		if (state_q == ccr_pkg::ST_ERR)  err_q <= err_d;
		if (out_load) begin
			out_re_q <= ore_q;
			out_im_q <= oim_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ccr_pkg::ST_IDLE;
			kp_q        <= '0;
			ki_q        <= '0;
			rcount_q    <= ccr_pkg::RESET_COUNT_INIT;
			integ_q     <= '0;
			phase_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					ccr_pkg::CFG_KP:          kp_q     <= cfg_data;
					ccr_pkg::CFG_KI:          ki_q     <= cfg_data;
					ccr_pkg::CFG_RESET_COUNT: rcount_q <= cfg_data[ccr_pkg::RCNT_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				if (clr) phase_q <= '0;
				if (cnt_q != ccr_pkg::CNT_MAX) cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == ccr_pkg::ST_MULP)
				integ_q <= integ_q + step;
			if (state_q == ccr_pkg::ST_PHASE)
				phase_q <= phase_q + step + integ_q;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.re    = out_re_q;
	assign out_ch.im    = out_im_q;

endmodule

[rtl/ccr_checker.sv]
// ----------------------------------------------------------------------------
// ccr_checker
// Port-level checks of the carrier recovery loop, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ccr_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [SAMPLE_WIDTH-1:0] out_re,
	input logic [SAMPLE_WIDTH-1:0] out_im
);

	logic       in_acc, out_acc;
	logic [1:0] pend_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready ##1 !in_ready)
		else $error("input taken again right after an item");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_re) && $stable(out_im))
		else $error("stalled result changed or dropped");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result with no item outstanding");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two items outstanding");

endmodule

bind qpsk_carrier_recovery_loop_core ccr_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_ccr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_re    (out_ch.re),
	.out_im    (out_ch.im)
);

[sim/qpsk_carrier_recovery_loop_core_tb.sv]
// ----------------------------------------------------------------------------
// qpsk_carrier_recovery_loop_core_tb
// Self-checking bench for the QPSK carrier recovery loop. A scoreboard class
// tracks the loop phase, integrator and sample counter and predicts each
// de-rotated sample. Gains and the clear count are reprogrammed between phases
// while the core is idle. Traffic runs under varied source and sink throttling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module qpsk_carrier_recovery_loop_core_tb;

	localparam int  SW             = 16;
	localparam int  N_PHASES       = 5;
	localparam int  ITEMS_PER_PH   = 340;
	localparam int  DRAIN_CYCLES   = 40;
	localparam int  CYCLE_LIMIT    = 1000000;
	localparam int  MAX_REPORTS    = 10;
	localparam int  CW             = ccr_pkg::COEF_WIDTH;
	localparam logic [ccr_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

	localparam longint INV_K      = 39797;   // 1/K, Q0.16
	localparam int     ROT_SHIFT  = 30;      // guard bits plus gain bits
	localparam longint ARCTAN_STEP [16] = '{
		536870912, 316933406, 167458907, 85004756,
		42667331, 21354465, 10680862, 5340245,
		2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861
	};

	typedef struct {
		logic signed [SW-1:0] re;
		logic signed [SW-1:0] im;
	} sample_t;

	class loop_scoreboard;
		logic signed [CW-1:0]               kp;
		logic signed [CW-1:0]               ki;
		logic [ccr_pkg::RCNT_W-1:0]         clear_at;
		logic [31:0]                        integ;
		logic [31:0]                        phase;
		logic [ccr_pkg::CNT_W-1:0]          count;
		sample_t                            expected_out[$];
		int                                 mismatches;

		function new();
			kp         = '0;
			ki         = '0;
			clear_at   = ccr_pkg::RESET_COUNT_INIT;
			integ      = '0;
			phase      = '0;
			count      = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [ccr_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] data);
			case (idx)
				ccr_pkg::CFG_KP:          kp = data;
				ccr_pkg::CFG_KI:          ki = data;
				ccr_pkg::CFG_RESET_COUNT: clear_at = data[ccr_pkg::RCNT_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clip(longint v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		// de-rotate by the current phase, then advance the loop
		function void note_sample(logic signed [SW-1:0] in_re, logic signed [SW-1:0] in_im);
			longint  x, y, z, dx, dy, t, ore, oim, sr, si, err, kpv, kiv, prop, ival;
			logic [31:0]     ang;
			ccr_pkg::quad_t  quad;
			sample_t         s;
			if (count == {1'b0, clear_at})
				phase = '0;
			ang  = 32'd0 - phase;
			quad = ccr_pkg::quad_t'(ang[31:30]);
			z    = longint'({2'b00, ang[29:0]});
			x    = in_re;
			y    = in_im;
			case (quad)
				ccr_pkg::QUAD_90: begin
					t = x; x = -y; y = t;
				end
				ccr_pkg::QUAD_180: begin
					x = -x; y = -y;
				end
				ccr_pkg::QUAD_270: begin
					t = x; x = y; y = -t;
				end
				default: ;
			endcase
			x = x * 16384;
			y = y * 16384;
			for (int i = 0; i < ccr_pkg::CORDIC_ITERS; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx; y = y + dy; z = z - ARCTAN_STEP[i];
				end else begin
					x = x + dx; y = y - dy; z = z + ARCTAN_STEP[i];
				end
			end
			ore  = clip((x * INV_K + (longint'(1) << (ROT_SHIFT - 1))) >>> ROT_SHIFT);
			oim  = clip((y * INV_K + (longint'(1) << (ROT_SHIFT - 1))) >>> ROT_SHIFT);
			s.re = ore[SW-1:0];
			s.im = oim[SW-1:0];
			expected_out.push_back(s);

			// zero counts as negative in the decision
			sr   = (ore > 0) ? 1 : -1;
			si   = (oim > 0) ? 1 : -1;
			err  = sr * oim - si * ore;
			kpv  = kp;
			kiv  = ki;
			ival = (kiv * err) >>> ccr_pkg::FILT_SHIFT;
			integ = integ + ival[31:0];
			prop = (kpv * err) >>> ccr_pkg::FILT_SHIFT;
			phase = phase + prop[31:0] + integ;
			if (count < ccr_pkg::CNT_MAX)
				count = count + 1'b1;
		endfunction

		function void check_sample(logic signed [SW-1:0] re, logic signed [SW-1:0] im);
			sample_t e;
			if (expected_out.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected output item re=%0d im=%0d", re, im);
				return;
			end
			e = expected_out.pop_front();
			if (e.re !== re || e.im !== im) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
						e.re, e.im, re, im);
			end
		endfunction

		function int pending();
			return expected_out.size();
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [ccr_pkg::CFG_IDX_W-1:0]     cfg_idx;
	logic [CW-1:0]                     cfg_data;

	ccr_stream_if #(.W(SW)) in_ch ();
	ccr_stream_if #(.W(SW)) out_ch ();

	qpsk_carrier_recovery_loop_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	loop_scoreboard model = new();
	int  src_idle_pct = 0;
	int  snk_stall_pct = 0;
	int  cycles = 0;
	real carrier_ph = 0.0;
	real carrier_step = 0.0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// sink throttling
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			model.check_sample(out_ch.re, out_ch.im);
	end

	function automatic logic signed [SW-1:0] clamp16(int v);
		if (v > 32767)
			return 16'sd32767;
		if (v < -32768)
			return -16'sd32768;
		return v[SW-1:0];
	endfunction

	function automatic logic signed [SW-1:0] corner_value();
		case ($urandom_range(5))
			0:       return -16'sd32768;
			1:       return -16'sd1;
			2:       return 16'sd0;
			3:       return 16'sd1;
			4:       return 16'sd32767;
			default: return SW'($urandom);
		endcase
	endfunction

	task automatic write_reg(input logic [ccr_pkg::CFG_IDX_W-1:0] idx,
			input logic [CW-1:0] data);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		model.write_reg(idx, data);
	endtask

	task automatic program_loop(input logic [CW-1:0] kp_v, input logic [CW-1:0] ki_v,
			input logic [CW-1:0] rc_v, input bit poke_unused);
		write_reg(ccr_pkg::CFG_KP, kp_v);
		write_reg(ccr_pkg::CFG_KI, ki_v);
		write_reg(ccr_pkg::CFG_RESET_COUNT, rc_v);
		if (poke_unused)
			write_reg(CFG_IDX_UNUSED, CW'($urandom));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (model.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// valid stays high into the next item when no gap is drawn
	task automatic send_sample(input logic signed [SW-1:0] re, input logic signed [SW-1:0] im);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			in_ch.re    <= SW'($urandom);
			in_ch.im    <= SW'($urandom);
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.re    <= re;
		in_ch.im    <= im;
		do
			@(posedge clk);
		while (!in_ch.ready);
		model.note_sample(re, im);
	endtask

	task automatic end_burst();
		@(negedge clk);
		in_ch.valid <= 1'b0;
	endtask

	// mostly rotated QPSK with noise, some full-range and corner items
	task automatic make_sample(output logic signed [SW-1:0] re, output logic signed [SW-1:0] im);
		int  pick, amp, sym, nr, ni;
		real a;
		pick = $urandom_range(99);
		if (pick < 70) begin
			amp = $urandom_range(23000, 4000);
			sym = $urandom_range(3);
			nr  = $urandom_range(1200);
			ni  = $urandom_range(1200);
			carrier_ph = carrier_ph + carrier_step;
			a  = carrier_ph + 0.785398 + sym * 1.570796;
			re = clamp16($rtoi(amp * $cos(a)) + nr - 600);
			im = clamp16($rtoi(amp * $sin(a)) + ni - 600);
		end else if (pick < 90) begin
			re = SW'($urandom);
			im = SW'($urandom);
		end else begin
			re = corner_value();
			im = corner_value();
		end
	endtask

	initial begin
		logic signed [SW-1:0] dir_re [22];
		logic signed [SW-1:0] dir_im [22];
		logic signed [SW-1:0] re, im;
		logic [CW-1:0] kp_v, ki_v, rc_v;
		int step;

		dir_re = '{0, -32768, 32767, -32768, 32767, 0, 0, 12345, -12345, 1, -1,
			23170, -23170, -23170, 23170, 32767, 0, -32768, 0, 1, -1, 20000};
		dir_im = '{0, -32768, 32767, 32767, -32768, 12345, -12345, 0, 0, -1, 1,
			23170, 23170, -23170, -23170, 0, 32767, 0, -32768, 1, -1, -5000};

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_idx     = '0;
		cfg_data    = '0;
		in_ch.valid = 1'b0;
		in_ch.re    = '0;
		in_ch.im    = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// clear count left at its reset value so the first clear uses it
		write_reg(ccr_pkg::CFG_KP, 18'd100000);
		write_reg(ccr_pkg::CFG_KI, 18'd2000);
		@(negedge clk);
		cfg_we <= 1'b0;
		foreach (dir_re[i])
			send_sample(dir_re[i], dir_im[i]);
		end_burst();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: begin
					kp_v = 18'h1FFFF; ki_v = 18'h1FFFF; rc_v = 18'd64;
					src_idle_pct = 0;  snk_stall_pct = 0;
				end
				1: begin
					kp_v = 18'h20000; ki_v = 18'h20000; rc_v = 18'd0;
					src_idle_pct = 57; snk_stall_pct = 0;
				end
				2: begin
					kp_v = CW'($urandom); ki_v = CW'($urandom); rc_v = 18'h3FFFF;
					src_idle_pct = 0;  snk_stall_pct = 57;
				end
				3: begin
					kp_v = '0; ki_v = '0; rc_v = CW'($urandom);
					src_idle_pct = 33; snk_stall_pct = 33;
				end
				default: begin
					kp_v = 18'd60000; ki_v = 18'd500; rc_v = CW'($urandom);
					src_idle_pct = 0;  snk_stall_pct = 0;
				end
			endcase
			// phase 0 keeps the clear count at its reset value
			if (ph == 0) begin
				write_reg(ccr_pkg::CFG_KP, kp_v);
				write_reg(ccr_pkg::CFG_KI, ki_v);
				@(negedge clk);
				cfg_we <= 1'b0;
			end else begin
				program_loop(kp_v, ki_v, rc_v, ph == N_PHASES - 1);
			end
			step = $urandom_range(200);
			carrier_step = (step - 100) * 1.0e-3;
			for (int n = 0; n < ITEMS_PER_PH; n++) begin
				make_sample(re, im);
				send_sample(re, im);
			end
			end_burst();
		end

		wait_idle();
		if (model.mismatches == 0 && model.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
